### rtl/hmpi_pkg.sv
// Shared types and constants for the hit maximum projection image block.
`default_nettype none

package hmpi_pkg;

  // Request codes carried by the req_type field.
  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_HIT   = 2'd1,
    REQ_READ  = 2'd2
  } hmpi_req_t;

  // Configuration register indexes (byte address is four times the index).
  typedef enum logic [1:0] {
    CFG_COLOR_MODE   = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2,
    CFG_MAX_AMP      = 2'd3
  } hmpi_cfg_idx_t;

  localparam int CFG_AW = 4;

  // Number of quotient bits produced by the serial divider.
  localparam int DIV_STEPS = 16;

  // One pixel as held in the frame store.
  typedef struct packed {
    logic [7:0] gray;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } hmpi_pixel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic abort_clear;
    logic abort_set;
    logic div_start;
    logic rd_en;
    logic pix_load;
    logic wr_en;
    logic wr_clear;
    logic clr_cnt_reset;
    logic out_load;
  } hmpi_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    hmpi_req_t req;
    logic      abort;
    logic      in_frame;
    logic      gray_mode;
    logic      div_done;
    logic      clr_last;
  } hmpi_status_t;

endpackage

`default_nettype wire

### rtl/hit_max_projection_image.sv
// Top level: configuration registers, controller and datapath of the projection image.
// One transaction is in work at a time: a gray hit runs the 16-step serial divider, and a start
// clears the whole frame store, one store pixel per cycle. The next transaction is accepted in
// the cycle after the result is registered. Synchronous reset clears the sticky out-of-frame
// flag and the configuration registers, then sweeps the whole frame store with input not
// ready; configuration writes are still taken.
`default_nettype none

module hit_max_projection_image #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [hmpi_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   req_type,
  input  wire logic signed [15:0]           col,
  input  wire logic signed [15:0]           row,
  input  wire logic [7:0]                   intensity,
  input  wire logic [7:0]                   red_in,
  input  wire logic [7:0]                   green_in,
  input  wire logic [7:0]                   blue_in,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [7:0]                   gray_out,
  output logic      [7:0]                   red_out,
  output logic      [7:0]                   green_out,
  output logic      [7:0]                   blue_out,
  output logic                              error_flag
);

  import hmpi_pkg::*;

  logic          color_mode;
  logic [8:0]    frame_width;
  logic [8:0]    frame_height;
  logic [7:0]    max_amp;
  logic          cfg_wr;
  hmpi_cfg_idx_t cfg_idx;
  hmpi_cmd_t     cmd;
  hmpi_status_t  status;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = hmpi_cfg_idx_t'(paddr[3:2]);

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode   <= 1'b0;
      frame_width  <= 9'd256;
      frame_height <= 9'd256;
      max_amp      <= 8'd255;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        CFG_COLOR_MODE:   color_mode   <= pwdata[0];
        CFG_FRAME_WIDTH:  frame_width  <= pwdata[8:0];
        CFG_FRAME_HEIGHT: frame_height <= pwdata[8:0];
        CFG_MAX_AMP:      max_amp      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Configuration register read-back.
  always_comb begin
    unique case (cfg_idx)
      CFG_COLOR_MODE:   prdata = {31'd0, color_mode};
      CFG_FRAME_WIDTH:  prdata = {23'd0, frame_width};
      CFG_FRAME_HEIGHT: prdata = {23'd0, frame_height};
      CFG_MAX_AMP:      prdata = {24'd0, max_amp};
      default:          prdata = '0;
    endcase
  end

  hmpi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  hmpi_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .req_type     (req_type),
    .col          (col),
    .row          (row),
    .intensity    (intensity),
    .red_in       (red_in),
    .green_in     (green_in),
    .blue_in      (blue_in),
    .color_mode   (color_mode),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .max_amp      (max_amp),
    .gray_out     (gray_out),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .error_flag   (error_flag)
  );

endmodule

`default_nettype wire

### rtl/hmpi_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hmpi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/hmpi_div.sv
// Restoring serial divider producing one quotient bit per cycle.
`default_nettype none

module hmpi_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] dividend,
  input  wire logic [7:0]  divisor,
  output logic      [15:0] quotient,
  output logic             done
);

  import hmpi_pkg::*;

  localparam int CW = $clog2(DIV_STEPS);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [7:0]    rem;
  logic [7:0]    dsr;
  logic [8:0]    trial;
  logic [8:0]    diff;
  logic          ge;

  // Trial subtraction of the divisor from the shifted partial remainder.
  assign trial = {rem, quotient[15]};
  assign ge    = (trial >= {1'b0, dsr});
  assign diff  = trial - {1'b0, dsr};

  // Step control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CW'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      rem      <= ge ? diff[7:0] : trial[7:0];
      quotient <= {quotient[14:0], ge};
    end
  end

endmodule

`default_nettype wire

### rtl/hmpi_datapath.sv
// Datapath: item registers, frame store, pixel update arithmetic and result registers.
`default_nettype none

module hmpi_datapath #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire hmpi_pkg::hmpi_cmd_t   cmd,
  output hmpi_pkg::hmpi_status_t     status,
  input  wire logic [1:0]            req_type,
  input  wire logic signed [15:0]    col,
  input  wire logic signed [15:0]    row,
  input  wire logic [7:0]            intensity,
  input  wire logic [7:0]            red_in,
  input  wire logic [7:0]            green_in,
  input  wire logic [7:0]            blue_in,
  input  wire logic                  color_mode,
  input  wire logic [8:0]            frame_width,
  input  wire logic [8:0]            frame_height,
  input  wire logic [7:0]            max_amp,
  output logic      [7:0]            gray_out,
  output logic      [7:0]            red_out,
  output logic      [7:0]            green_out,
  output logic      [7:0]            blue_out,
  output logic                       error_flag
);

  import hmpi_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CB    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RB    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam logic [15:0]   MAXW16 = 16'(MAX_WIDTH);
  localparam logic [15:0]   MAXH16 = 16'(MAX_HEIGHT);
  localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);
  localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);
  // Reciprocal of three for sums below 768: floor(x * 683 / 2048).
  localparam logic [19:0]   RECIP3 = 20'd683;

  logic [1:0]    req_q;
  logic [15:0]   col_q;
  logic [15:0]   row_q;
  logic [7:0]    int_q;
  logic [7:0]    red_q;
  logic [7:0]    grn_q;
  logic [7:0]    blu_q;
  logic          abort;
  hmpi_pixel_t   pix;
  logic [AW-1:0] pix_addr;
  logic [AW-1:0] clr_cnt;

  logic [15:0]   w_eff;
  logic [15:0]   h_eff;
  logic          in_frame;
  logic [AW-1:0] addr;
  logic [15:0]   dividend;
  logic [7:0]    divisor;
  logic [15:0]   quotient;
  logic          div_done;
  logic [7:0]    gray_scaled;
  logic [9:0]    rgb_sum;
  logic [19:0]   rgb_prod;
  hmpi_pixel_t   new_pix;
  hmpi_pixel_t   rd_pix;
  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  hmpi_pixel_t   ram_wr_data;

  // Capture the accepted transaction.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req_type;
      col_q <= col;
      row_q <= row;
      int_q <= intensity;
      red_q <= red_in;
      grn_q <= green_in;
      blu_q <= blue_in;
    end
  end

  // Frame bounds limited to the store size; negative coordinates are large unsigned values.
  assign w_eff    = ({7'd0, frame_width} > MAXW16) ? MAXW16 : {7'd0, frame_width};
  assign h_eff    = ({7'd0, frame_height} > MAXH16) ? MAXH16 : {7'd0, frame_height};
  assign in_frame = (col_q < w_eff) && (row_q < h_eff);
  assign addr     = AW'(row_q[RB-1:0]) * ROW_STRIDE + AW'(col_q[CB-1:0]);

  // Sticky out-of-frame flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      abort <= 1'b0;
    end else if (cmd.abort_clear) begin
      abort <= 1'b0;
    end else if (cmd.abort_set) begin
      abort <= 1'b1;
    end
  end

  // Clearing pass address counter.
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_cnt_reset) begin
      clr_cnt <= '0;
    end else if (cmd.wr_clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Gray scaling: 255 * intensity / max_amp, with max_amp of zero taken as one.
  assign dividend = 16'(int_q) * 16'd255;
  assign divisor  = (max_amp == 8'd0) ? 8'd1 : max_amp;

  hmpi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  assign gray_scaled = (quotient > 16'd255) ? 8'd255 : quotient[7:0];

  // Rounded mean of the three colour components.
  assign rgb_sum  = 10'(red_q) + 10'(grn_q) + 10'(blu_q) + 10'd1;
  assign rgb_prod = 20'(rgb_sum) * RECIP3;

  // Updated pixel for a hit.
  always_comb begin
    new_pix = pix;
    if (!color_mode) begin
      if (gray_scaled > pix.gray) begin
        new_pix.gray = gray_scaled;
      end
    end else if (grn_q > pix.green) begin
      new_pix.gray  = rgb_prod[18:11];
      new_pix.red   = red_q;
      new_pix.green = grn_q;
      new_pix.blue  = blu_q;
    end
  end

  // Hold the stored pixel and its address for the update.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pix <= '0;
    end else if (cmd.pix_load) begin
      pix <= rd_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      pix_addr <= addr;
    end
  end

  // Frame store write selection between the clearing pass and hit updates.
  assign ram_wr_en   = cmd.wr_en || cmd.wr_clear;
  assign ram_wr_addr = cmd.wr_clear ? clr_cnt : pix_addr;
  assign ram_wr_data = cmd.wr_clear ? '0 : new_pix;

  hmpi_ram #(
    .WIDTH ($bits(hmpi_pixel_t)),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (addr),
    .rd_data (rd_pix)
  );

  // Result registers; pixel fields are shown for read transactions only.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (hmpi_req_t'(req_q) == REQ_READ) begin
        gray_out  <= pix.gray;
        red_out   <= pix.red;
        green_out <= pix.green;
        blue_out  <= pix.blue;
      end else begin
        gray_out  <= '0;
        red_out   <= '0;
        green_out <= '0;
        blue_out  <= '0;
      end
      error_flag <= abort;
    end
  end

  // Status towards the controller.
  assign status.req       = hmpi_req_t'(req_q);
  assign status.abort     = abort;
  assign status.in_frame  = in_frame;
  assign status.gray_mode = !color_mode;
  assign status.div_done  = div_done;
  assign status.clr_last  = (clr_cnt == LAST_ADDR);

endmodule

`default_nettype wire

### rtl/hmpi_ctrl.sv
// Controller state machine sequencing each transaction through the datapath.
`default_nettype none

module hmpi_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  input  wire hmpi_pkg::hmpi_status_t status,
  output hmpi_pkg::hmpi_cmd_t         cmd
);

  import hmpi_pkg::*;

  typedef enum logic [2:0] {
    S_INIT_CLEAR,
    S_IDLE,
    S_DECODE,
    S_CLEAR,
    S_READ,
    S_DIV,
    S_WRITE,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_INIT_CLEAR: begin
        cmd.wr_clear = 1'b1;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (status.req)
          REQ_START: begin
            cmd.abort_clear   = 1'b1;
            cmd.clr_cnt_reset = 1'b1;
            state_next        = S_CLEAR;
          end
          REQ_HIT: begin
            if (status.abort) begin
              state_next = S_FINISH;
            end else if (!status.in_frame) begin
              cmd.abort_set = 1'b1;
              state_next    = S_FINISH;
            end else begin
              cmd.rd_en     = 1'b1;
              cmd.div_start = status.gray_mode;
              state_next    = S_READ;
            end
          end
          REQ_READ: begin
            if (status.in_frame) begin
              cmd.rd_en  = 1'b1;
              state_next = S_READ;
            end else begin
              state_next = S_FINISH;
            end
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_CLEAR: begin
        cmd.wr_clear = 1'b1;
        if (status.clr_last) begin
          state_next = S_FINISH;
        end
      end
      S_READ: begin
        cmd.pix_load = 1'b1;
        if (status.req == REQ_HIT) begin
          state_next = status.gray_mode ? S_DIV : S_WRITE;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.wr_en  = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and result valid register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
